@@ design/gnf_pkg.sv @@
// ----------------------------------------------------------------------------
// gnf_pkg
// Shared types and constants of the fixed-point gradient noise fBm block.
// ----------------------------------------------------------------------------
package gnf_pkg;

   localparam int PERM_ENTRIES = 256;
   localparam int OCT_W        = 4;

   // Input item modes.
   localparam logic [1:0] MODE_LOAD_PERM = 2'd0;
   localparam logic [1:0] MODE_LOAD_GRAD = 2'd1;
   localparam logic [1:0] MODE_SAMPLE    = 2'd2;

   // Register indexes.
   localparam logic CSR_BASE_FREQUENCY = 1'b0;
   localparam logic CSR_OCTAVE_COUNT   = 1'b1;

   localparam logic [23:0] BASE_FREQUENCY_RESET = 24'd65536;
   localparam logic [3:0]  OCTAVE_COUNT_RESET   = 4'd1;

   // Quintic fade constants: 15 and 10 in Q.16.
   localparam logic [20:0] FADE_A0 = 21'd983040;
   localparam logic [20:0] FADE_B0 = 21'd655360;

   localparam logic signed [23:0] SUM_MAX = 24'sd524287;
   localparam logic signed [23:0] SUM_MIN = -24'sd524288;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WR_PERM,
      OP_WR_GRAD,
      OP_SCALE,
      OP_SPLIT,
      OP_PERM_RD,
      OP_DOT,
      OP_FADE,
      OP_LERP,
      OP_ACCUM,
      OP_EMIT
   } gnf_op_type;

   typedef struct packed {
      gnf_op_type       op;
      logic [2:0]       sel;
      logic [OCT_W-1:0] octave;
   } gnf_cmd_type;

   typedef struct packed {
      logic out_free;
   } gnf_status_type;

endpackage

@@ design/gnf_req_if.sv @@
// ----------------------------------------------------------------------------
// gnf_req_if
// Input channel: load and sample items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gnf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [7:0]         table_index;
   logic [7:0]         perm_value;
   logic signed [15:0] grad_x;
   logic signed [15:0] grad_y;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;

   modport source (output valid, mode, table_index, perm_value, grad_x, grad_y,
                   coord_x, coord_y, input ready);
   modport sink (input valid, mode, table_index, perm_value, grad_x, grad_y,
                 coord_x, coord_y, output ready);
endinterface

@@ design/gnf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gnf_rsp_if
// Result channel: one summed noise value per sample item.
// ----------------------------------------------------------------------------
interface gnf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

@@ design/gnf_ctrl.sv @@
// ----------------------------------------------------------------------------
// gnf_ctrl
// Sequencer: steps the datapath through table loads, scaling, octave loop and emission.
// ----------------------------------------------------------------------------
module gnf_ctrl #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_mode,
   input  logic [3:0]              octave_count,
   input  gnf_pkg::gnf_status_type status,
   output gnf_pkg::gnf_cmd_type    cmd,
   output logic                    req_ready
);
   import gnf_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN, ST_EMIT} state_type;

   localparam logic [OCT_W-1:0] LAST_MAX = OCT_W'(MAX_OCTAVES - 1);

   state_type        state_ff;
   gnf_cmd_type      cmd_ff;
   logic             ready_ff;
   logic [OCT_W-1:0] last_ff;
   logic [OCT_W-1:0] last_in;

   // Zero octaves means one; more than the maximum are clamped.
   always_comb begin
      if (octave_count == 4'd0) begin
         last_in = '0;
      end else if (OCT_W'(octave_count - 4'd1) > LAST_MAX) begin
         last_in = LAST_MAX;
      end else begin
         last_in = OCT_W'(octave_count - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '{op: OP_NOP, sel: '0, octave: '0};
         ready_ff <= 1'b1;
         last_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  last_ff  <= last_in;
                  priority if (req_mode == MODE_LOAD_PERM) begin
                     cmd_ff   <= '{op: OP_WR_PERM, sel: '0, octave: '0};
                     state_ff <= ST_LOAD;
                  end else if (req_mode == MODE_LOAD_GRAD) begin
                     cmd_ff   <= '{op: OP_WR_GRAD, sel: '0, octave: '0};
                     state_ff <= ST_LOAD;
                  end else if (req_mode == MODE_SAMPLE) begin
                     cmd_ff   <= '{op: OP_SCALE, sel: '0, octave: '0};
                     state_ff <= ST_RUN;
                  end else begin
                     cmd_ff   <= '{op: OP_NOP, sel: '0, octave: '0};
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  cmd_ff <= '{op: OP_NOP, sel: '0, octave: '0};
               end
            end
            ST_LOAD: begin
               cmd_ff   <= '{op: OP_NOP, sel: '0, octave: '0};
               ready_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_RUN: begin
               unique case (cmd_ff.op)
                  OP_SCALE: begin
                     if (cmd_ff.sel == 3'd0) begin
                        cmd_ff.sel <= 3'd1;
                     end else begin
                        cmd_ff.op  <= OP_SPLIT;
                        cmd_ff.sel <= '0;
                     end
                  end
                  OP_SPLIT: begin
                     cmd_ff.op  <= OP_PERM_RD;
                     cmd_ff.sel <= '0;
                  end
                  OP_PERM_RD: begin
                     if (cmd_ff.sel == 3'd6) begin
                        cmd_ff.op  <= OP_DOT;
                        cmd_ff.sel <= '0;
                     end else begin
                        cmd_ff.sel <= cmd_ff.sel + 3'd1;
                     end
                  end
                  OP_DOT: begin
                     if (cmd_ff.sel == 3'd7) begin
                        cmd_ff.op <= OP_FADE;
                     end
                     cmd_ff.sel <= cmd_ff.sel + 3'd1;
                  end
                  OP_FADE: begin
                     if (cmd_ff.sel == 3'd7) begin
                        cmd_ff.op <= OP_LERP;
                     end
                     cmd_ff.sel <= cmd_ff.sel + 3'd1;
                  end
                  OP_LERP: begin
                     if (cmd_ff.sel == 3'd2) begin
                        cmd_ff.op  <= OP_ACCUM;
                        cmd_ff.sel <= '0;
                     end else begin
                        cmd_ff.sel <= cmd_ff.sel + 3'd1;
                     end
                  end
                  OP_ACCUM: begin
                     if (cmd_ff.octave == last_ff) begin
                        cmd_ff   <= '{op: OP_NOP, sel: '0, octave: '0};
                        state_ff <= ST_EMIT;
                     end else begin
                        cmd_ff.op     <= OP_SPLIT;
                        cmd_ff.octave <= cmd_ff.octave + OCT_W'(1);
                     end
                  end
                  default: begin
                     cmd_ff   <= '{op: OP_NOP, sel: '0, octave: '0};
                     state_ff <= ST_EMIT;
                  end
               endcase
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  cmd_ff   <= '{op: OP_EMIT, sel: '0, octave: '0};
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign cmd       = cmd_ff;
   assign req_ready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == ST_IDLE)
      else $error("ready raised outside idle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd_ff.op == OP_EMIT |-> $past(status.out_free))
      else $error("result emitted into a full output register");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cmd_ff.octave <= last_ff)
      else $error("octave index past the last octave");

endmodule

@@ design/gnf_datapath.sv @@
// ----------------------------------------------------------------------------
// gnf_datapath
// Tables, shared multiplier and working registers of the noise evaluation.
// ----------------------------------------------------------------------------
module gnf_datapath #(
   parameter int GRADIENT_COUNT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              req_table_index,
   input  logic [7:0]              req_perm_value,
   input  logic signed [15:0]      req_grad_x,
   input  logic signed [15:0]      req_grad_y,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   input  logic [23:0]             base_frequency,
   input  gnf_pkg::gnf_cmd_type    cmd,
   output gnf_pkg::gnf_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [19:0]      rsp_noise_value
);
   import gnf_pkg::*;

   localparam int GIW = (GRADIENT_COUNT > 1) ? $clog2(GRADIENT_COUNT) : 1;

   // Captured item.
   logic [7:0]         index_ff;
   logic [7:0]         pval_ff;
   logic [31:0]        grad_ff;
   logic signed [31:0] cx_ff;
   logic signed [31:0] cy_ff;

   logic [7:0]  perm_mem [PERM_ENTRIES];
   logic [31:0] grad_mem [GRADIENT_COUNT];
   logic [7:0]  rd_ff;
   logic [7:0]  rd_addr;
   logic [GIW-1:0] mod_lut [PERM_ENTRIES];

   logic [55:0]        px_ff, py_ff;
   logic [55:0]        shx, shy;
   logic [15:0]        tx_ff, ty_ff;
   logic [7:0]         cellx_ff, celly_ff;
   logic [7:0]         h0_ff, h1_ff;
   logic [GIW-1:0]     gi_ff [4];
   logic signed [34:0] acc_ff;
   logic signed [19:0] dot_ff [4];
   logic [20:0]        f_ff;
   logic [16:0]        fade_ff [2];
   logic signed [20:0] ly_ff [2];
   logic signed [20:0] oct_ff;
   logic signed [23:0] sum_ff;
   logic               out_valid_ff;
   logic signed [19:0] noise_ff;

   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [57:0] prod;
   logic [31:0]        grad_sel;
   logic [1:0]         corner;
   logic [15:0]        t_sel;
   logic [20:0]        fade_a;
   logic signed [21:0] diff;
   logic signed [34:0] dot_sum;

   // Gradient index is the hash reduced modulo the table size.
   for (genvar g = 0; g < PERM_ENTRIES; g++) begin : g_mod
      assign mod_lut[g] = GIW'(g % GRADIENT_COUNT);
   end

   assign corner   = cmd.sel[2:1];
   assign grad_sel = grad_mem[gi_ff[corner]];
   assign t_sel    = cmd.sel[2] ? ty_ff : tx_ff;
   assign fade_a   = FADE_A0 - 21'(t_sel) * 21'd6;
   assign shx      = px_ff << cmd.octave;
   assign shy      = py_ff << cmd.octave;

   always_comb begin
      unique case (cmd.sel[1:0])
         2'd0:    diff = 22'(dot_ff[1]) - 22'(dot_ff[0]);
         2'd1:    diff = 22'(dot_ff[3]) - 22'(dot_ff[2]);
         default: diff = 22'(ly_ff[1]) - 22'(ly_ff[0]);
      endcase
   end

   always_comb begin
      unique case (cmd.sel)
         3'd0:    rd_addr = cellx_ff;
         3'd1:    rd_addr = cellx_ff + 8'd1;
         3'd2:    rd_addr = h0_ff + celly_ff;
         3'd3:    rd_addr = h0_ff + celly_ff + 8'd1;
         3'd4:    rd_addr = h1_ff + celly_ff;
         3'd5:    rd_addr = h1_ff + celly_ff + 8'd1;
         default: rd_addr = cellx_ff;
      endcase
   end

   // Operand selection of the one shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SCALE: begin
            mul_a = cmd.sel[0] ? 33'(cy_ff) : 33'(cx_ff);
            mul_b = $signed({1'b0, base_frequency});
         end
         OP_DOT: begin
            if (cmd.sel[0]) begin
               mul_a = 33'($signed({corner[0], ty_ff}));
               mul_b = 25'($signed(grad_sel[31:16]));
            end else begin
               mul_a = 33'($signed({corner[1], tx_ff}));
               mul_b = 25'($signed(grad_sel[15:0]));
            end
         end
         OP_FADE: begin
            mul_a = (cmd.sel[1:0] == 2'd0) ? $signed({12'b0, fade_a})
                                           : $signed({12'b0, f_ff});
            mul_b = $signed({9'b0, t_sel});
         end
         OP_LERP: begin
            mul_a = 33'(diff);
            mul_b = (cmd.sel[1:0] == 2'd2) ? $signed({8'b0, fade_ff[0]})
                                           : $signed({8'b0, fade_ff[1]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign dot_sum = acc_ff + 35'(prod);

   always_ff @(posedge clock) begin
      if (accept) begin
         index_ff <= req_table_index;
         pval_ff  <= req_perm_value;
         grad_ff  <= {req_grad_y, req_grad_x};
         cx_ff    <= req_coord_x;
         cy_ff    <= req_coord_y;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WR_PERM) begin
         perm_mem[index_ff] <= pval_ff;
      end
      rd_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WR_GRAD && index_ff < 8'(GRADIENT_COUNT)) begin
         grad_mem[index_ff[GIW-1:0]] <= grad_ff;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_SCALE: begin
            if (cmd.sel[0]) begin
               py_ff <= prod[55:0];
            end else begin
               px_ff  <= prod[55:0];
               sum_ff <= '0;
            end
         end
         OP_SPLIT: begin
            tx_ff    <= shx[31:16];
            ty_ff    <= shy[31:16];
            cellx_ff <= shx[39:32];
            celly_ff <= shy[39:32];
         end
         OP_PERM_RD: begin
            // Read data is registered and arrives in the cycle after its address.
            unique case (cmd.sel)
               3'd1:    h0_ff <= rd_ff;
               3'd2:    h1_ff <= rd_ff;
               3'd3, 3'd4, 3'd5, 3'd6: gi_ff[2'(cmd.sel - 3'd3)] <= mod_lut[rd_ff];
               default: ;
            endcase
         end
         OP_DOT: begin
            if (cmd.sel[0]) begin
               dot_ff[corner] <= 20'(dot_sum >>> 14);
            end else begin
               acc_ff <= 35'(prod);
            end
         end
         OP_FADE: begin
            unique case (cmd.sel[1:0])
               2'd0:    f_ff <= FADE_B0 - prod[36:16];
               2'd3:    fade_ff[cmd.sel[2]] <= prod[32:16];
               default: f_ff <= prod[36:16];
            endcase
         end
         OP_LERP: begin
            unique case (cmd.sel[1:0])
               2'd0:    ly_ff[0] <= 21'(dot_ff[0]) + 21'(prod >>> 16);
               2'd1:    ly_ff[1] <= 21'(dot_ff[2]) + 21'(prod >>> 16);
               default: oct_ff   <= ly_ff[0] + 21'(prod >>> 16);
            endcase
         end
         OP_ACCUM: begin
            sum_ff <= sum_ff + 24'(oct_ff >>> cmd.octave);
         end
         OP_EMIT: begin
            priority if (sum_ff > SUM_MAX) begin
               noise_ff <= 20'(SUM_MAX);
            end else if (sum_ff < SUM_MIN) begin
               noise_ff <= 20'(SUM_MIN);
            end else begin
               noise_ff <= 20'(sum_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_noise_value = noise_ff;

endmodule

@@ design/gradient_noise_fbm_2d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_fbm_2d
// Two-dimensional gradient noise summed over octaves, in fixed point.
// ----------------------------------------------------------------------------
// Items arrive on req_bus. Mode 0 writes one permutation entry, mode 1 writes
// one gradient vector, mode 2 evaluates the noise sum at coord_x, coord_y and
// returns one beat on rsp_bus; other items give no beat.
// A sample runs the coordinate scaling once, then the octave loop, then the
// emission. Its length is set by the one shared multiplier, which serves the
// coordinate scaling, eight dot-product terms, eight fade steps and three
// interpolations of each octave, and by the single read port of the
// permutation memory, which gives the six hashes of an octave one by one.
// The result waits in an output register; the next item is taken while it
// waits, and a finished sample holds until the register is free.
// Reset sets base_frequency to 1.0 and octave_count to 1 and empties the
// output register; both tables hold nothing defined until loaded. The user
// must write configuration on csr_write_enable while idle; it is not enforced.
// ----------------------------------------------------------------------------
module gradient_noise_fbm_2d #(
   parameter int GRADIENT_COUNT = 8,
   parameter int MAX_OCTAVES    = 8
) (
   input  logic         clock,
   input  logic         reset,
   gnf_req_if.sink      req_bus,
   gnf_rsp_if.source    rsp_bus,
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [23:0]  csr_write_data
);
   import gnf_pkg::*;

   logic [23:0]    base_frequency_ff;
   logic [3:0]     octave_count_ff;
   logic           ready;
   logic           accept;
   gnf_cmd_type    cmd;
   gnf_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frequency_ff <= BASE_FREQUENCY_RESET;
         octave_count_ff   <= OCTAVE_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE_FREQUENCY: base_frequency_ff <= csr_write_data;
            CSR_OCTAVE_COUNT:   octave_count_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   assign req_bus.ready = ready;
   assign accept        = req_bus.valid && ready;

   gnf_ctrl #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_mode     (req_bus.mode),
      .octave_count (octave_count_ff),
      .status       (status),
      .cmd          (cmd),
      .req_ready    (ready)
   );

   gnf_datapath #(
      .GRADIENT_COUNT (GRADIENT_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_table_index (req_bus.table_index),
      .req_perm_value  (req_bus.perm_value),
      .req_grad_x      (req_bus.grad_x),
      .req_grad_y      (req_bus.grad_y),
      .req_coord_x     (req_bus.coord_x),
      .req_coord_y     (req_bus.coord_y),
      .base_frequency  (base_frequency_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_noise_value (rsp_bus.noise_value)
   );

endmodule
